// ===== src/rse_pkg.sv =====
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types and constants of the RPN stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package rse_pkg;

  // Operand width and stack sizing
  localparam int DATA_W      = 32;
  localparam int STACK_DEPTH = 128;
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_W);
  localparam int KIND_W      = 3;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 8;

  // Token kinds; code 7 is unused and handled as an unknown operator
  typedef enum logic [KIND_W-1:0] {
    REQ_PUSH    = 3'd0,
    REQ_ADD     = 3'd1,
    REQ_SUB     = 3'd2,
    REQ_MUL     = 3'd3,
    REQ_DIV     = 3'd4,
    REQ_UNKNOWN = 3'd5,
    REQ_END     = 3'd6
  } req_kind_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_FINAL = 3'd4,
    ST_FERR  = 3'd5,
    ST_HALT  = 3'd6
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_OPER,
    S_DIVW,
    S_RTOP,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== src/rse_req_if.sv =====
// ----------------------------------------------------------------------------
// rse_req_if
// Token channel: valid/ready handshake carrying one postfix token.
// ----------------------------------------------------------------------------
`default_nettype none

interface rse_req_if;
  logic                             valid;
  logic                             ready;
  logic [rse_pkg::KIND_W-1:0]       req_type;
  logic signed [rse_pkg::DATA_W-1:0] operand_value;

  modport source (output valid, output req_type, output operand_value, input ready);
  modport sink   (input valid, input req_type, input operand_value, output ready);
endinterface

`default_nettype wire

// ===== src/rse_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rse_rsp_if
// Result channel: valid/ready handshake carrying one status item per token.
// ----------------------------------------------------------------------------
`default_nettype none

interface rse_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [rse_pkg::STATUS_W-1:0]      status;
  logic signed [rse_pkg::DATA_W-1:0] result_value;
  logic [rse_pkg::COUNT_W-1:0]       stack_count;

  modport source (output valid, output status, output result_value, output stack_count,
                  input ready);
  modport sink   (input valid, input status, input result_value, input stack_count,
                  output ready);
endinterface

`default_nettype wire

// ===== src/rse_stack_ram.sv =====
// ----------------------------------------------------------------------------
// rse_stack_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_stack_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  wire                                   clk,
  input  wire                                   wr_en,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire  [WIDTH-1:0]                      wr_data,
  input  wire                                   rd_en,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/rse_divider.sv =====
// ----------------------------------------------------------------------------
// rse_divider
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_divider (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  input  wire  [rse_pkg::DATA_W-1:0]    dividend,
  input  wire  [rse_pkg::DATA_W-1:0]    divisor,
  output logic                          done,
  output logic [rse_pkg::DATA_W-1:0]    quotient
);

  logic                            busy;
  logic [rse_pkg::DIV_CNT_W-1:0]   cnt;
  logic [rse_pkg::DATA_W-1:0]      quo;
  logic [rse_pkg::DATA_W-1:0]      rem;
  logic [rse_pkg::DATA_W-1:0]      dvs;
  logic                            neg;
  logic [rse_pkg::DATA_W:0]        rem_sh;
  logic [rse_pkg::DATA_W:0]        diff;
  logic [rse_pkg::DATA_W-1:0]      abs_a;
  logic [rse_pkg::DATA_W-1:0]      abs_b;

  // Magnitudes; the most negative value maps to its unsigned magnitude
  assign abs_a = dividend[rse_pkg::DATA_W-1] ? (~dividend + 1'b1) : dividend;
  assign abs_b = divisor[rse_pkg::DATA_W-1]  ? (~divisor + 1'b1)  : divisor;

  // Shift in the next dividend bit and trial-subtract
  assign rem_sh = {rem, quo[rse_pkg::DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == rse_pkg::DIV_CNT_W'(rse_pkg::DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= abs_a;
      rem <= '0;
      dvs <= abs_b;
      neg <= dividend[rse_pkg::DATA_W-1] ^ divisor[rse_pkg::DATA_W-1];
    end else if (busy) begin
      if (!diff[rse_pkg::DATA_W]) begin
        rem <= diff[rse_pkg::DATA_W-1:0];
        quo <= {quo[rse_pkg::DATA_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[rse_pkg::DATA_W-1:0];
        quo <= {quo[rse_pkg::DATA_W-2:0], 1'b0};
      end
    end
  end

  // Apply the sign; the magnitude of min/-1 wraps back to min
  assign quotient = neg ? (~quo + 1'b1) : quo;

endmodule

`default_nettype wire

// ===== src/rpn_stack_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_unit
// Integer postfix expression evaluator on a RAM-backed operand stack.
// ----------------------------------------------------------------------------
// Each token transfer on req yields one result transfer on rsp. The block
// takes one token at a time. A push, an underflow, an overflow, a halted token
// or an end token goes from evaluation straight to the result. Add, subtract,
// multiply, a divide by zero and an unknown operator that empties the stack
// also pass through an operand state for the stack RAM read of the left
// operand. An unknown operator that leaves entries behind then reads the RAM
// again to refill the cached top. A divide waits for the bit-serial divider.
// The top of the stack is held in a register; all entries also live in the
// stack RAM. A finished result sits in the output register, so the next
// token is taken while rsp is stalled. The stack RAM needs no clearing after
// reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_evaluator_unit (
  input  wire     clk,
  input  wire     rst,
  rse_req_if.sink   req,
  rse_rsp_if.source rsp
);

  localparam int DW = rse_pkg::DATA_W;
  localparam int CW = rse_pkg::CNT_W;
  localparam int PW = rse_pkg::PTR_W;

  rse_pkg::state_t    state, state_next;
  rse_pkg::req_kind_t kind;
  logic [DW-1:0]      num;
  logic [CW-1:0]      depth, depth_next;
  logic               err, err_next;
  logic [DW-1:0]      top, top_next;
  rse_pkg::status_t   res_status, status_next;

  logic               out_valid;
  rse_pkg::status_t   out_status;
  logic [DW-1:0]      out_value;
  logic [rse_pkg::COUNT_W-1:0] out_count;
  logic               out_load;

  logic               wr_en;
  logic [PW-1:0]      wr_addr;
  logic [DW-1:0]      wr_data;
  logic               rd_en;
  logic [PW-1:0]      rd_addr;
  logic [DW-1:0]      rd_data;

  logic               div_start;
  logic               div_done;
  logic [DW-1:0]      div_q;

  logic [CW-1:0]      dm1, dm2, dm3;
  logic [DW-1:0]      arith;
  logic [CW+rse_pkg::COUNT_W-1:0] count_wide;
  logic [DW-1:0]      value_sel;

  rse_stack_ram #(
    .DEPTH (rse_pkg::STACK_DEPTH),
    .WIDTH (DW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rse_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_data),
    .divisor  (top),
    .done     (div_done),
    .quotient (div_q)
  );

  assign dm1 = depth - CW'(1);
  assign dm2 = depth - CW'(2);
  assign dm3 = depth - CW'(3);

  // Left operand comes from RAM, right operand is the cached top
  always_comb begin
    case (kind)
      rse_pkg::REQ_ADD: arith = rd_data + top;
      rse_pkg::REQ_SUB: arith = rd_data - top;
      rse_pkg::REQ_MUL: arith = rd_data * top;
      default:          arith = rd_data + top;
    endcase
  end

  // Sequencer: next state, stack update and RAM control
  always_comb begin
    state_next  = state;
    depth_next  = depth;
    err_next    = err;
    top_next    = top;
    status_next = res_status;
    wr_en       = 1'b0;
    wr_addr     = depth[PW-1:0];
    wr_data     = num;
    rd_en       = 1'b0;
    rd_addr     = dm2[PW-1:0];
    div_start   = 1'b0;

    case (state)
      rse_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = rse_pkg::S_EVAL;
        end
      end

      rse_pkg::S_EVAL: begin
        state_next  = rse_pkg::S_DONE;
        status_next = rse_pkg::ST_OK;
        if (kind == rse_pkg::REQ_END) begin
          status_next = (!err && depth == CW'(1)) ? rse_pkg::ST_FINAL : rse_pkg::ST_FERR;
          depth_next  = '0;
          err_next    = 1'b0;
        end else if (err) begin
          status_next = rse_pkg::ST_HALT;
        end else if (kind == rse_pkg::REQ_PUSH) begin
          if (depth == CW'(rse_pkg::STACK_DEPTH)) begin
            status_next = rse_pkg::ST_OVER;
            err_next    = 1'b1;
          end else begin
            wr_en      = 1'b1;
            top_next   = num;
            depth_next = depth + CW'(1);
          end
        end else if (depth < CW'(2)) begin
          status_next = rse_pkg::ST_UNDER;
          err_next    = 1'b1;
        end else begin
          // Fetch the left operand
          rd_en      = 1'b1;
          state_next = rse_pkg::S_OPER;
        end
      end

      rse_pkg::S_OPER: begin
        case (kind)
          rse_pkg::REQ_ADD, rse_pkg::REQ_SUB, rse_pkg::REQ_MUL: begin
            wr_en      = 1'b1;
            wr_addr    = dm2[PW-1:0];
            wr_data    = arith;
            top_next   = arith;
            depth_next = dm1;
            state_next = rse_pkg::S_DONE;
          end
          rse_pkg::REQ_DIV: begin
            if (top == '0) begin
              status_next = rse_pkg::ST_DIVZ;
              err_next    = 1'b1;
              state_next  = rse_pkg::S_DONE;
            end else begin
              div_start  = 1'b1;
              state_next = rse_pkg::S_DIVW;
            end
          end
          default: begin
            // Unknown operator: drop both operands, refill the cached top if entries remain
            depth_next = dm2;
            if (dm2 != '0) begin
              rd_en      = 1'b1;
              rd_addr    = dm3[PW-1:0];
              state_next = rse_pkg::S_RTOP;
            end else begin
              state_next = rse_pkg::S_DONE;
            end
          end
        endcase
      end

      rse_pkg::S_DIVW: begin
        if (div_done) begin
          wr_en      = 1'b1;
          wr_addr    = dm2[PW-1:0];
          wr_data    = div_q;
          top_next   = div_q;
          depth_next = dm1;
          state_next = rse_pkg::S_DONE;
        end
      end

      rse_pkg::S_RTOP: begin
        top_next   = rd_data;
        state_next = rse_pkg::S_DONE;
      end

      rse_pkg::S_DONE: begin
        if (out_load) begin
          state_next = rse_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = rse_pkg::S_IDLE;
      end
    endcase
  end

  // Hold the result in DONE until the output register is free
  assign out_load   = (state == rse_pkg::S_DONE) && (!out_valid || rsp.ready);
  assign count_wide = {{rse_pkg::COUNT_W{1'b0}}, depth};
  assign value_sel  = (res_status == rse_pkg::ST_FINAL) ? top :
                      ((depth != '0) ? top : '0);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rse_pkg::S_IDLE;
      depth      <= '0;
      err        <= 1'b0;
      res_status <= rse_pkg::ST_OK;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      depth      <= depth_next;
      err        <= err_next;
      res_status <= status_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top <= top_next;
    if (state == rse_pkg::S_IDLE && req.valid) begin
      kind <= rse_pkg::req_kind_t'(req.req_type);
      num  <= req.operand_value;
    end
    if (out_load) begin
      out_status <= res_status;
      out_value  <= value_sel;
      out_count  <= count_wide[rse_pkg::COUNT_W-1:0];
    end
  end

  assign req.ready        = (state == rse_pkg::S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.result_value = out_value;
  assign rsp.stack_count  = out_count;

endmodule

`default_nettype wire

// ===== tb/rpn_stack_evaluator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_unit_tb
// Self-checking testbench for the postfix stack evaluator.
// ----------------------------------------------------------------------------
// Tokens go in on the req channel and each result coming back on rsp is
// compared, field by field, with a local stack calculator that runs on every
// accepted token. A short table covers reset, wraparound, signed division
// extremes and each fault kind but overflow. A full-stack fill and a deep
// reduction follow. Random expressions come last, mostly well formed, with
// cut-short expressions and token noise mixed in. Both sides idle at random
// in some phases and not in others. The result side also holds off once for
// a long stretch, and the token side drains everything once in a while.
// ----------------------------------------------------------------------------

module rpn_stack_evaluator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rse_pkg::*;

  localparam logic [KIND_W-1:0] REQ_UNUSED = 3'd7;
  localparam int RANDOM_TOKENS = 200;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_IDLE = 13;
  localparam int N_DIRECTED = 26;

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   value;
    logic [COUNT_W-1:0]  count;
  } outcome_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [DATA_W-1:0]   num;
    logic                typed;
    outcome_t            want;
  } token_row_t;

  logic clk;
  logic rst;

  rse_req_if req_ch ();
  rse_rsp_if rsp_ch ();

  rpn_stack_evaluator_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Local copy of the calculator state
  logic [DATA_W-1:0] calc_stack [STACK_DEPTH];
  int                calc_depth;
  logic              calc_fault;

  outcome_t    pending_results [$];
  token_row_t  directed_rows [N_DIRECTED];

  int  mismatches;
  int  tokens_sent;
  int  results_seen;
  int  seen_status [8];
  int  hold_offs;
  bit  tok_idle;
  bit  rsp_idle;
  bit  hold_off_req;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Evaluate one token on the local stack and return the result it should give
  function automatic outcome_t eval_token(input logic [KIND_W-1:0] kind,
                                          input logic [DATA_W-1:0] num);
    outcome_t          o;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] res;
    bit                keep_res;

    o = '0;
    o.status = ST_OK;
    res = '0;
    keep_res = 1'b1;
    if (kind == REQ_END) begin
      if (!calc_fault && calc_depth == 1) begin
        o.status = ST_FINAL;
        o.value = calc_stack[0];
      end else begin
        o.status = ST_FERR;
      end
      calc_depth = 0;
      calc_fault = 1'b0;
      return o;
    end
    if (calc_fault) begin
      o.status = ST_HALT;
    end else if (kind == REQ_PUSH) begin
      if (calc_depth >= STACK_DEPTH) begin
        o.status = ST_OVER;
        calc_fault = 1'b1;
      end else begin
        calc_stack[calc_depth] = num;
        calc_depth++;
      end
    end else if (calc_depth < 2) begin
      o.status = ST_UNDER;
      calc_fault = 1'b1;
    end else begin
      rhs = calc_stack[calc_depth-1];
      lhs = calc_stack[calc_depth-2];
      case (kind)
        REQ_ADD: res = lhs + rhs;
        REQ_SUB: res = lhs - rhs;
        REQ_MUL: res = lhs * rhs;
        REQ_DIV: begin
          if (rhs == '0) begin
            o.status = ST_DIVZ;
            calc_fault = 1'b1;
          end else if (lhs == 32'h8000_0000 && rhs == 32'hFFFF_FFFF) begin
            // most negative over minus one wraps back to itself
            res = lhs;
          end else begin
            res = $signed(lhs) / $signed(rhs);
          end
        end
        default: keep_res = 1'b0;
      endcase
      if (o.status == ST_OK) begin
        calc_depth -= 2;
        if (keep_res) begin
          calc_stack[calc_depth] = res;
          calc_depth++;
        end
      end
    end
    o.value = (calc_depth == 0) ? '0 : calc_stack[calc_depth-1];
    o.count = calc_depth[COUNT_W-1:0];
    return o;
  endfunction

  function automatic logic [DATA_W-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'hFFFF_FFFF;
      4, 5, 6: return 32'($urandom_range(0, 20)) - 32'd10;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] pick_op();
    case ($urandom_range(0, 12))
      0, 1, 2:  return REQ_ADD;
      3, 4, 5:  return REQ_SUB;
      6, 7, 8:  return REQ_MUL;
      9, 10, 11: return REQ_DIV;
      default:  return REQ_UNKNOWN;
    endcase
  endfunction

  // Offer one token, wait for its transfer, then queue the result it should give
  task automatic send_token(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] num,
                            input bit typed = 1'b0, input outcome_t typed_want = '0);
    int       gap;
    outcome_t predicted;

    gap = tok_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= kind;
    req_ch.operand_value <= num;
    do @(posedge clk); while (!req_ch.ready);
    predicted = eval_token(kind, num);
    pending_results.push_back(typed ? typed_want : predicted);
    tokens_sent++;
  endtask

  // Pause the token side until every queued result has come back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Emit one expression ending in an end token; cut_at < 0 means run to completion
  task automatic emit_expression(input int n_push, input bit pushes_first, input int cut_at);
    int                d;
    int                left;
    int                emitted;
    logic [KIND_W-1:0] op;

    d = 0;
    left = n_push;
    emitted = 0;
    while ((left > 0 || d > 1) && emitted != cut_at) begin
      if (d >= 2 && (left == 0 || d >= STACK_DEPTH ||
                     (!pushes_first && $urandom_range(0, 2) == 0))) begin
        op = pick_op();
        send_token(op, $urandom());
        d -= (op == REQ_UNKNOWN) ? 2 : 1;
      end else begin
        send_token(REQ_PUSH, rand_operand());
        d++;
        left--;
      end
      emitted++;
    end
    send_token(REQ_END, $urandom());
  endtask

  // Token side: reset, directed table, full-stack cases, random expressions
  initial begin
    int phase;
    int rand_start;

    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.req_type      <= REQ_PUSH;
    req_ch.operand_value <= '0;
    calc_depth   = 0;
    calc_fault   = 1'b0;
    mismatches   = 0;
    tokens_sent  = 0;
    hold_offs    = 0;
    tok_idle     = 1'b1;
    rsp_idle     = 1'b1;
    hold_off_req = 1'b0;

    directed_rows = '{
      '{REQ_END,     32'd0,         1'b1, '{ST_FERR,  32'd0,         8'd0}},
      '{REQ_ADD,     32'd0,         1'b1, '{ST_UNDER, 32'd0,         8'd0}},
      '{REQ_PUSH,    32'd5,         1'b1, '{ST_HALT,  32'd0,         8'd0}},
      '{REQ_END,     32'd0,         1'b1, '{ST_FERR,  32'd0,         8'd0}},
      '{REQ_PUSH,    32'h7FFF_FFFF, 1'b1, '{ST_OK,    32'h7FFF_FFFF, 8'd1}},
      '{REQ_PUSH,    32'd1,         1'b1, '{ST_OK,    32'd1,         8'd2}},
      '{REQ_ADD,     32'd0,         1'b1, '{ST_OK,    32'h8000_0000, 8'd1}},
      '{REQ_PUSH,    32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'hFFFF_FFFF, 8'd2}},
      '{REQ_DIV,     32'd0,         1'b1, '{ST_OK,    32'h8000_0000, 8'd1}},
      '{REQ_PUSH,    32'd3,         1'b0, '0},
      '{REQ_MUL,     32'd0,         1'b0, '0},
      '{REQ_PUSH,    32'd7,         1'b0, '0},
      '{REQ_SUB,     32'd0,         1'b0, '0},
      '{REQ_PUSH,    32'hFFFF_FFF9, 1'b0, '0},
      '{REQ_PUSH,    32'd2,         1'b0, '0},
      '{REQ_DIV,     32'd0,         1'b0, '0},
      '{REQ_UNKNOWN, 32'd0,         1'b1, '{ST_OK,    32'd0,         8'd0}},
      '{REQ_PUSH,    32'd9,         1'b0, '0},
      '{REQ_PUSH,    32'd0,         1'b0, '0},
      '{REQ_DIV,     32'd0,         1'b1, '{ST_DIVZ,  32'd0,         8'd2}},
      '{REQ_END,     32'd0,         1'b1, '{ST_FERR,  32'd0,         8'd0}},
      '{REQ_PUSH,    32'd42,        1'b0, '0},
      '{REQ_END,     32'd0,         1'b1, '{ST_FINAL, 32'd42,        8'd0}},
      '{REQ_PUSH,    32'd1,         1'b0, '0},
      '{REQ_PUSH,    32'd2,         1'b0, '0},
      '{REQ_UNUSED,  32'd0,         1'b1, '{ST_OK,    32'd0,         8'd0}}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    foreach (directed_rows[i])
      send_token(directed_rows[i].kind, directed_rows[i].num,
                 directed_rows[i].typed, directed_rows[i].want);

    // Fill the stack one past full, then push a full stack and reduce it
    repeat (STACK_DEPTH + 1) send_token(REQ_PUSH, rand_operand());
    send_token(REQ_END, $urandom());
    emit_expression(STACK_DEPTH, 1'b1, -1);
    drain_results();

    // Random expressions in phases with different idling
    rand_start = tokens_sent;
    phase = 0;
    while (tokens_sent - rand_start < RANDOM_TOKENS) begin
      tok_idle = (phase % 4) != 1;
      rsp_idle = (phase % 4) != 2 && (phase % 4) != 1;
      if (phase == 3) begin
        // long output stall with tokens pushed back to back
        tok_idle = 1'b0;
        hold_off_req = 1'b1;
      end
      case ($urandom_range(0, 9))
        7:       emit_expression($urandom_range(2, 12), 1'b0, $urandom_range(0, 6));
        8: begin
          repeat ($urandom_range(1, 8))
            send_token(KIND_W'($urandom_range(0, 7)), rand_operand());
          send_token(REQ_END, $urandom());
        end
        9: begin
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2))
              send_token(REQ_PUSH, rand_operand());
            send_token(REQ_END, $urandom());
          end else begin
            emit_expression($urandom_range(1, 40), 1'b0, -1);
          end
        end
        default: emit_expression($urandom_range(1, 12), 1'b0, -1);
      endcase
      if (phase % 5 == 4) drain_results();
      phase++;
    end

    // Let the last results come back
    drain_results();
    repeat (60) @(posedge clk);
    $display("Ran %0d tokens (%0d random), %0d results checked, %0d long output stalls.",
             tokens_sent, tokens_sent - rand_start, results_seen, hold_offs);
    $display({"Status mix: ok %0d, underflow %0d, overflow %0d, div-by-zero %0d, ",
              "final %0d, final error %0d, halted %0d."},
             seen_status[ST_OK], seen_status[ST_UNDER], seen_status[ST_OVER],
             seen_status[ST_DIVZ], seen_status[ST_FINAL], seen_status[ST_FERR],
             seen_status[ST_HALT]);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side: stall at random, hold off on request, check each transfer
  initial begin
    int       stall;
    outcome_t want;

    rsp_ch.ready <= 1'b0;
    results_seen = 0;
    foreach (seen_status[i]) seen_status[i] = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_req) begin
        stall = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
        hold_offs++;
      end else begin
        stall = rsp_idle ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);

      // Compare the transfer with the oldest queued result
      results_seen++;
      seen_status[rsp_ch.status]++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing queued: status %0d value %0h count %0d",
                 $time, rsp_ch.status, rsp_ch.result_value, rsp_ch.stack_count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_ch.status);
          mismatches++;
        end
        if (rsp_ch.result_value !== want.value) begin
          $display("%0t: result_value expected %0h, got %0h",
                   $time, want.value, rsp_ch.result_value);
          mismatches++;
        end
        if (rsp_ch.stack_count !== want.count) begin
          $display("%0t: stack_count expected %0d, got %0d",
                   $time, want.count, rsp_ch.stack_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
src/rse_pkg.sv
src/rse_req_if.sv
src/rse_rsp_if.sv
src/rse_stack_ram.sv
src/rse_divider.sv
src/rpn_stack_evaluator_unit.sv
tb/rpn_stack_evaluator_unit_tb.sv
